[rtl/core/slip_frame_decoder_assert.svh]
// Assertion helpers for the SLIP frame decoder.
// They expect signals named clk and arst_n in the including scope.
`ifndef SLIP_FRAME_DECODER_ASSERT_SVH
`define SLIP_FRAME_DECODER_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define SFD_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("sfd assertion failed: never");

// The antecedent implies the consequent at the same clock edge.
`define SFD_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfd assertion failed: implication");

`endif

[rtl/core/sfd_pkg.sv]
package sfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned MAX_PAYLOAD = 1024;
	localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1024);

	localparam logic [BYTE_W-1:0] BYTE_START = 8'hCF;
	localparam logic [BYTE_W-1:0] BYTE_END = 8'hC0;
	localparam logic [BYTE_W-1:0] BYTE_ESC = 8'hDB;
	localparam logic [BYTE_W-1:0] BYTE_ESC_START = 8'hDE;
	localparam logic [BYTE_W-1:0] BYTE_ESC_END = 8'hDC;
	localparam logic [BYTE_W-1:0] BYTE_ESC_ESC = 8'hDD;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CUT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INCOMPLETE_ESC = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID_ESC = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

	typedef enum logic [2:0] {
		KIND_DATA,
		KIND_START,
		KIND_END,
		KIND_ESC,
		KIND_ESC_START,
		KIND_ESC_END,
		KIND_ESC_ESC
	} byte_kind_t;

	typedef struct packed {
		byte_kind_t kind;
		logic [BYTE_W-1:0] raw;
	} queue_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic byte_kind_t classify(input logic [BYTE_W-1:0] b);
		byte_kind_t k;
		k = KIND_DATA;
		if (b == BYTE_START) begin
			k = KIND_START;
		end else if (b == BYTE_END) begin
			k = KIND_END;
		end else if (b == BYTE_ESC) begin
			k = KIND_ESC;
		end else if (b == BYTE_ESC_START) begin
			k = KIND_ESC_START;
		end else if (b == BYTE_ESC_END) begin
			k = KIND_ESC_END;
		end else if (b == BYTE_ESC_ESC) begin
			k = KIND_ESC_ESC;
		end
		return k;
	endfunction

endpackage

[rtl/core/sfd_front.sv]
module sfd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [sfd_pkg::BYTE_W-1:0] in_byte,
	input  sfd_pkg::queue_status_t    q_status,
	output logic                      push,
	output sfd_pkg::queue_entry_t     push_entry
);

	logic                  valid_s1;
	sfd_pkg::queue_entry_t entry_s1;

	assign push       = valid_s1 && !q_status.full;
	assign in_ready   = !valid_s1 || !q_status.full;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1.kind <= sfd_pkg::classify(in_byte);
			entry_s1.raw  <= in_byte;
		end
	end

endmodule

[rtl/core/sfd_queue.sv]
module sfd_queue #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  sfd_pkg::queue_entry_t  push_entry,
	input  logic                   pop,
	output sfd_pkg::queue_entry_t  head,
	output sfd_pkg::queue_status_t status
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	sfd_pkg::queue_entry_t slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_FULL);
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[rtl/core/sfd_back.sv]
module sfd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sfd_pkg::LEN_W-1:0]    limit,
	input  sfd_pkg::queue_entry_t        head,
	input  sfd_pkg::queue_status_t       q_status,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sfd_pkg::BYTE_W-1:0]   out_byte,
	output logic                         frame_done,
	output logic [sfd_pkg::STATUS_W-1:0] status,
	output logic [sfd_pkg::LEN_W-1:0]    frame_length
);

	logic                         in_frame_q;
	logic                         escape_q;
	logic [sfd_pkg::LEN_W-1:0]    count_q;
	logic                         out_valid_q;
	logic [sfd_pkg::BYTE_W-1:0]   out_byte_q;
	logic                         done_q;
	logic [sfd_pkg::STATUS_W-1:0] status_q;
	logic [sfd_pkg::LEN_W-1:0]    length_q;

	logic                         in_frame_d;
	logic                         escape_d;
	logic [sfd_pkg::LEN_W-1:0]    count_d;
	logic                         emit;
	logic                         emit_end;
	logic [sfd_pkg::STATUS_W-1:0] emit_status;
	logic [sfd_pkg::BYTE_W-1:0]   emit_byte;
	logic                         want_byte;
	logic [sfd_pkg::BYTE_W-1:0]   data_byte;
	logic                         bad_escape;

	assign pop = !q_status.empty && (!out_valid_q || out_ready);

	always_comb begin
		bad_escape = 1'b0;
		data_byte  = head.raw;
		if (escape_q) begin
			unique case (head.kind)
				sfd_pkg::KIND_ESC_START: data_byte = sfd_pkg::BYTE_START;
				sfd_pkg::KIND_ESC_END:   data_byte = sfd_pkg::BYTE_END;
				sfd_pkg::KIND_ESC_ESC:   data_byte = sfd_pkg::BYTE_ESC;
				default:                 bad_escape = 1'b1;
			endcase
		end
	end

	always_comb begin
		in_frame_d  = in_frame_q;
		escape_d    = escape_q;
		count_d     = count_q;
		emit        = 1'b0;
		emit_end    = 1'b0;
		emit_status = sfd_pkg::ST_OK;
		emit_byte   = '0;
		want_byte   = 1'b0;
		priority if (!in_frame_q) begin
			if (head.kind == sfd_pkg::KIND_START) begin
				in_frame_d = 1'b1;
				escape_d   = 1'b0;
				count_d    = '0;
			end
		end else if (head.kind == sfd_pkg::KIND_START) begin
			emit        = 1'b1;
			emit_end    = 1'b1;
			emit_status = sfd_pkg::ST_CUT;
			escape_d    = 1'b0;
			count_d     = '0;
		end else if (head.kind == sfd_pkg::KIND_END) begin
			emit        = 1'b1;
			emit_end    = 1'b1;
			emit_status = escape_q ? sfd_pkg::ST_INCOMPLETE_ESC : sfd_pkg::ST_OK;
			in_frame_d  = 1'b0;
			escape_d    = 1'b0;
			count_d     = '0;
		end else if (escape_q && bad_escape) begin
			emit        = 1'b1;
			emit_end    = 1'b1;
			emit_status = sfd_pkg::ST_INVALID_ESC;
			in_frame_d  = 1'b0;
			escape_d    = 1'b0;
			count_d     = '0;
		end else if (!escape_q && head.kind == sfd_pkg::KIND_ESC) begin
			escape_d = 1'b1;
		end else begin
			want_byte = 1'b1;
		end

		if (want_byte) begin
			emit     = 1'b1;
			escape_d = 1'b0;
			if (count_q >= limit) begin
				emit_end    = 1'b1;
				emit_status = sfd_pkg::ST_OVERFLOW;
				in_frame_d  = 1'b0;
				count_d     = '0;
			end else begin
				emit_byte = data_byte;
				count_d   = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			escape_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			in_frame_q  <= in_frame_d;
			escape_q    <= escape_d;
			count_q     <= count_d;
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_byte_q <= emit_byte;
			done_q     <= emit_end;
			status_q   <= emit_status;
			length_q   <= emit_end ? count_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign frame_done   = done_q;
	assign status       = status_q;
	assign frame_length = length_q;

endmodule

[rtl/core/slip_frame_decoder.sv]
// SLIP frame decoder with an explicit start byte (0xCF), end byte (0xC0) and escape byte
// (0xDB). One encoded byte enters per word on s_axis and the block sustains one byte per
// clock cycle while m_axis is ready; input passes through the input stage, the queue and
// the result register, and a queue of QUEUE_DEPTH entries absorbs stalls on m_axis. Each
// payload byte gives one word with tlast low; each frame end, cut or error gives one word
// with tlast high, the status and the frame length. Bytes outside a frame give no word. The
// payload limit in force is the smaller of cfg_data as last written (reset 1024) and 1024;
// the user must write it only while the block is idle; the block itself does not enforce it.
module slip_frame_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_byte[7:0], status[10:8], frame_length[21:11], zero
	output logic        m_axis_tlast   // frame_done
);

	logic [sfd_pkg::LEN_W-1:0]    payload_limit_q;
	logic [sfd_pkg::LEN_W-1:0]    limit;
	logic                         push;
	logic                         pop;
	sfd_pkg::queue_entry_t        push_entry;
	sfd_pkg::queue_entry_t        head;
	sfd_pkg::queue_status_t       q_status;
	logic [sfd_pkg::BYTE_W-1:0]   out_byte;
	logic [sfd_pkg::STATUS_W-1:0] status;
	logic [sfd_pkg::LEN_W-1:0]    frame_length;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_limit_q <= sfd_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			payload_limit_q <= cfg_data;
		end
	end

	assign limit = (payload_limit_q > sfd_pkg::LEN_W'(sfd_pkg::MAX_PAYLOAD))
		? sfd_pkg::LEN_W'(sfd_pkg::MAX_PAYLOAD) : payload_limit_q;

	sfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	sfd_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	sfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.limit        (limit),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (out_byte),
		.frame_done   (m_axis_tlast),
		.status       (status),
		.frame_length (frame_length)
	);

	assign m_axis_tdata = {2'b00, frame_length, status, out_byte};

`include "slip_frame_decoder_assert.svh"

	`SFD_ASSERT_IMPLY(a_byte_word_clean, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[21:8] == '0)
	`SFD_ASSERT_NEVER(a_length_bound, m_axis_tvalid && m_axis_tdata[21:11] > 11'd1024)
	`SFD_ASSERT_IMPLY(a_stall_means_full, !s_axis_tready, q_status.full)
	`SFD_ASSERT_NEVER(a_pop_empty, pop && q_status.empty)

endmodule

[verif/slip_frame_checker.sv]
`timescale 1ns / 100ps

module slip_frame_checker
	import sfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [10:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          pending,
	output int          payload_seen,
	output int          ends_seen,
	output int          error_ends
);

	typedef struct packed {
		logic [BYTE_W-1:0]   data;
		logic                done;
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    length;
	} slip_word_t;

	slip_word_t decoded_words[$];
	logic [LEN_W-1:0] limit_reg;
	logic in_frame;
	logic esc_pending;
	logic [LEN_W-1:0] count;

	function automatic logic [LEN_W-1:0] limit_in_use();
		if (limit_reg > LEN_W'(MAX_PAYLOAD)) begin
			return LEN_W'(MAX_PAYLOAD);
		end
		return limit_reg;
	endfunction

	task automatic close_frame(input logic [STATUS_W-1:0] st);
		decoded_words.push_back(slip_word_t'{data: '0, done: 1'b1, status: st, length: count});
	endtask

	// A payload byte past the limit is dropped and ends the frame as an overflow.
	task automatic emit_payload(input logic [BYTE_W-1:0] b);
		if (count >= limit_in_use()) begin
			close_frame(ST_OVERFLOW);
			in_frame = 1'b0;
			esc_pending = 1'b0;
			count = '0;
		end else begin
			count = count + 1'b1;
			decoded_words.push_back(slip_word_t'{data: b, done: 1'b0, status: ST_OK,
				length: '0});
		end
	endtask

	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		if (!in_frame) begin
			if (b == BYTE_START) begin
				in_frame = 1'b1;
				esc_pending = 1'b0;
				count = '0;
			end
		end else if (b == BYTE_START) begin
			close_frame(ST_CUT);
			esc_pending = 1'b0;
			count = '0;
		end else if (b == BYTE_END) begin
			close_frame(esc_pending ? ST_INCOMPLETE_ESC : ST_OK);
			in_frame = 1'b0;
			esc_pending = 1'b0;
			count = '0;
		end else if (esc_pending) begin
			esc_pending = 1'b0;
			case (b)
				BYTE_ESC_START: emit_payload(BYTE_START);
				BYTE_ESC_END: emit_payload(BYTE_END);
				BYTE_ESC_ESC: emit_payload(BYTE_ESC);
				default: begin
					close_frame(ST_INVALID_ESC);
					in_frame = 1'b0;
					count = '0;
				end
			endcase
		end else if (b == BYTE_ESC) begin
			esc_pending = 1'b1;
		end else begin
			emit_payload(b);
		end
	endtask

	task automatic note_mismatch(input string what, input slip_word_t want, input slip_word_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected byte %02h done %0d status %0d length %0d, got byte %02h done %0d status %0d length %0d",
				$time, what, want.data, want.done, want.status, want.length,
				got.data, got.done, got.status, got.length);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		slip_word_t got;
		slip_word_t want;
		if (!arst_n) begin
			limit_reg = LIMIT_RESET;
			in_frame = 1'b0;
			esc_pending = 1'b0;
			count = '0;
			decoded_words.delete();
			mismatches = 0;
			pending = 0;
			payload_seen = 0;
			ends_seen = 0;
			error_ends = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = slip_word_t'{data: m_axis_tdata[7:0], done: m_axis_tlast,
					status: m_axis_tdata[10:8], length: m_axis_tdata[21:11]};
				if (got.done) begin
					ends_seen++;
					if (got.status != ST_OK) begin
						error_ends++;
					end
				end else begin
					payload_seen++;
				end
				if (decoded_words.size() == 0) begin
					note_mismatch("word with nothing expected", '0, got);
				end else begin
					want = decoded_words.pop_front();
					if (got.data !== want.data || got.done !== want.done ||
							got.status !== want.status || got.length !== want.length) begin
						note_mismatch("word mismatch", want, got);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				limit_reg = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata);
			end
			pending = decoded_words.size();
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import sfd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_BYTES = 45;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // in_byte[7:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // out_byte[7:0], status[10:8], frame_length[21:11], zero
	logic        m_axis_tlast;  // frame_done

	int mismatches;
	int pending;
	int payload_seen;
	int ends_seen;
	int error_ends;

	bit idling;
	int stall_left;
	int cycles;
	int bytes_sent;
	int noise_sent;
	logic [LEN_W-1:0] limit_now;

	logic [7:0] opening [26] = '{
		BYTE_END, BYTE_ESC, 8'h00,
		BYTE_START, 8'h00, 8'hFF, BYTE_ESC_START, BYTE_ESC_END, BYTE_ESC_ESC,
		BYTE_ESC, BYTE_ESC_START, BYTE_ESC, BYTE_ESC_END, BYTE_ESC, BYTE_ESC_ESC, BYTE_END,
		BYTE_START, BYTE_END,
		BYTE_START, 8'h41, BYTE_START, BYTE_ESC, BYTE_END,
		BYTE_START, BYTE_ESC, BYTE_ESC
	};

	slip_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	slip_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.mismatches(mismatches),
		.pending(pending),
		.payload_seen(payload_seen),
		.ends_seen(ends_seen),
		.error_ends(error_ends)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding.", cycles, pending);
			$display("[slip_frame_decoder] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 18);
		end
		m_axis_tready <= (stall_left == 0);
	end

	function automatic logic [7:0] plain_byte();
		logic [7:0] v;
		do begin
			v = 8'($urandom_range(0, 255));
		end while (v == BYTE_START || v == BYTE_END || v == BYTE_ESC);
		return v;
	endfunction

	function automatic logic [7:0] bad_escape();
		logic [7:0] v;
		if ($urandom_range(0, 3) == 0) begin
			return BYTE_ESC;
		end
		do begin
			v = 8'($urandom_range(0, 255));
		end while (v == BYTE_ESC_START || v == BYTE_ESC_END || v == BYTE_ESC_ESC ||
			v == BYTE_START || v == BYTE_END);
		return v;
	endfunction

	// Entered and left at a falling edge; valid stays high between back-to-back words.
	task automatic send_word(input logic [7:0] b);
		if (idling && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit(input logic [10:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		limit_now = v;
	endtask

	// Bytes between frames never include the start byte, so the decoder keeps hunting.
	task automatic send_noise();
		int n;
		logic [7:0] v;
		n = $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: v = BYTE_END;
				1: v = BYTE_ESC;
				default: v = bad_escape();
			endcase
			send_word(v);
		end
		noise_sent += n;
	endtask

	task automatic send_payload(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_word(plain_byte());
			end else if (r < 80) begin
				send_word(BYTE_ESC);
				case ($urandom_range(0, 2))
					0: send_word(BYTE_ESC_START);
					1: send_word(BYTE_ESC_END);
					default: send_word(BYTE_ESC_ESC);
				endcase
			end else begin
				case ($urandom_range(0, 4))
					0: send_word(8'h00);
					1: send_word(8'hFF);
					2: send_word(BYTE_ESC_START);
					3: send_word(BYTE_ESC_END);
					default: send_word(BYTE_ESC_ESC);
				endcase
			end
		end
	endtask

	// Mostly well-formed frames; the rest are cut, end mid-escape or carry a bad escape.
	task automatic send_frame();
		int n;
		int lim;
		int r;
		lim = (limit_now > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(limit_now);
		if ($urandom_range(0, 9) < 3) begin
			send_noise();
		end
		send_word(BYTE_START);
		n = $urandom_range(0, 10);
		if (lim <= 40 && $urandom_range(0, 3) == 0) begin
			n = lim + $urandom_range(0, 2);
		end
		send_payload(n);
		r = $urandom_range(0, 99);
		if (r < 70) begin
			send_word(BYTE_END);
		end else if (r < 80) begin
			send_word(BYTE_START);
			send_payload($urandom_range(0, 4));
			send_word(BYTE_END);
		end else if (r < 88) begin
			send_word(BYTE_ESC);
			send_word(BYTE_END);
		end else begin
			send_word(BYTE_ESC);
			send_word(bad_escape());
		end
	endtask

	task automatic run_phase(input int budget);
		int start;
		idling = ($urandom_range(0, 3) != 0);
		start = bytes_sent - noise_sent;
		while (bytes_sent - noise_sent - start < budget) begin
			send_frame();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b1;
		idling = 1'b1;
		stall_left = 0;
		cycles = 0;
		bytes_sent = 0;
		noise_sent = 0;
		limit_now = LIMIT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i]) begin
			send_word(opening[i]);
		end

		write_limit(11'd0);
		send_word(BYTE_START);
		send_word(8'h12);
		send_word(BYTE_START);
		send_word(BYTE_END);
		run_phase(PHASE_BYTES);

		write_limit(11'd1);
		run_phase(PHASE_BYTES);
		write_limit(11'd2);
		run_phase(PHASE_BYTES);

		write_limit(11'd2047);
		run_phase(PHASE_BYTES);

		write_limit(11'd1023);
		run_phase(PHASE_BYTES);
		write_limit(11'($urandom_range(3, 40)));
		run_phase(PHASE_BYTES);
		write_limit(11'($urandom_range(1025, 2046)));
		run_phase(PHASE_BYTES);
		write_limit(11'($urandom_range(1, 40)));
		run_phase(PHASE_BYTES);

		write_limit(11'd1024);
		run_phase(PHASE_BYTES);
		idling = 1'b0;
		while (stall_left != 0) @(negedge clk);
		repeat (30) send_frame();

		wait_idle();
		$display("Sent %0d bytes; checked %0d payload words and %0d frame ends.",
			bytes_sent, payload_seen, ends_seen);
		$display("Of the frame ends %0d were errors; payload limits from 0 to 2047 were used.",
			error_ends);
		if (mismatches == 0 && pending == 0) begin
			$display("[slip_frame_decoder] OK");
		end else begin
			$display("[slip_frame_decoder] ERROR");
		end
		$finish;
	end

endmodule
